### rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
// Holds the request and response beat structs and the register map.
// No dependencies.
`default_nettype none

package sfr_pkg;

   // Frame bytes kept for the payload store (frame positions 3 onward)
   localparam int PAYLOAD_BYTES = 4;

   // Width of the packed payload word reported on a good frame
   localparam int WORD_BYTES = 4;

   // First frame position that lands in the payload store
   localparam int FIRST_DATA_POS = 3;

   // Register indexes on the configuration port
   localparam logic REG_HEADER_VALUE  = 1'b0;
   localparam logic REG_TIMEOUT_LIMIT = 1'b1;

   localparam logic [7:0]  HEADER_RESET  = 8'd0;
   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] TICK_MAX      = 16'hFFFF;

   // Item kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        byte_accepted;
      logic        frame_error;
      logic        timed_out;
      logic        frame_done;
      logic [7:0]  frame_length;
      logic [7:0]  command_code;
      logic [31:0] payload_word;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/serial_frame_receiver.sv
// Serial frame receiver: header / length / command / data / checksum parser
// with tick-driven timeout, output register plus skid stage.
// Depends on sfr_pkg.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+-----------
//   request  | req_valid, req_ready, req_payload       | in
//   response | rsp_valid, rsp_ready, rsp_payload       | out
//   config   | psel, penable, pwrite, paddr, pwdata,   | in / out
//            | prdata, pready                          |
//
// Each beat (byte or tick) is parsed combinationally: the running checksum and
// the state registers update at acceptance, the result lands in the output
// register. One beat per cycle is sustained while rsp_ready stays high.
// A skid stage holds one more result, so a beat is taken while a result
// waits; req_ready falls only when both stages are full.
// Synchronous reset clears the parser, the registers and both stages.
`default_nettype none

module serial_frame_receiver
   import sfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_payload,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_LENGTH  = 2'd2;
   localparam logic [1:0] PH_COMMAND = 2'd3;

   logic [7:0]  header_ff;
   logic [15:0] limit_ff;

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  store_ff [PAYLOAD_BYTES];
   logic [7:0]  store_in [PAYLOAD_BYTES];
   logic        armed_ff, armed_in;
   logic [15:0] tick_ff, tick_in;

   rsp_type     result;
   rsp_type     out_ff, skid_ff;
   logic        out_valid_ff, skid_valid_ff;

   logic        accept;
   logic        out_free;
   logic        cfg_write;
   logic        reg_sel;

   logic [15:0] tick_next;
   logic [7:0]  want;
   logic        clear;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_sel   = paddr[2];

   always_comb begin
      case (reg_sel)
         REG_HEADER_VALUE:  prdata = {24'd0, header_ff};
         REG_TIMEOUT_LIMIT: prdata = {16'd0, limit_ff};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         limit_ff  <= TIMEOUT_RESET;
      end else if (cfg_write) begin
         case (reg_sel)
            REG_HEADER_VALUE:  header_ff <= pwdata[7:0];
            REG_TIMEOUT_LIMIT: limit_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign req_ready   = !skid_valid_ff;
   assign accept      = req_valid && req_ready;
   assign out_free    = !out_valid_ff || rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // ---------------- parser ----------------
   assign tick_next = (tick_ff < TICK_MAX) ? tick_ff + 16'd1 : tick_ff;

   always_comb begin
      if (len_ff >= 8'd4) begin
         want = sum_ff;
      end else if (len_ff == 8'd3) begin
         want = sum_ff - cmd_ff;
      end else if (len_ff == 8'd2) begin
         want = sum_ff - cmd_ff - len_ff;
      end else begin
         want = 8'd0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      cmd_in   = cmd_ff;
      armed_in = armed_ff;
      tick_in  = tick_ff;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         store_in[k] = store_ff[k];
      end
      clear  = 1'b0;
      result = '0;

      if (req_payload.operation == OP_TICK) begin
         if (armed_ff) begin
            tick_in = tick_next;
            if (tick_next >= limit_ff) begin
               clear            = 1'b1;
               result.timed_out = 1'b1;
            end
         end
      end else begin
         armed_in = 1'b1;
         tick_in  = 16'd0;
         count_in = count_ff + 8'd1;
         case (phase_ff)
            PH_IDLE: begin
               result.byte_accepted = (req_payload.rx_byte == header_ff);
               if (result.byte_accepted) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               len_in               = req_payload.rx_byte;
               phase_in             = PH_LENGTH;
               result.byte_accepted = 1'b1;
            end
            PH_LENGTH: begin
               cmd_in               = req_payload.rx_byte;
               phase_in             = PH_COMMAND;
               result.byte_accepted = 1'b1;
            end
            default: begin
               result.byte_accepted = 1'b1;
               if (count_in >= len_ff) begin
                  if (want != req_payload.rx_byte) begin
                     result.byte_accepted = 1'b0;
                     result.frame_error   = 1'b1;
                  end else begin
                     result.frame_done = 1'b1;
                  end
               end
            end
         endcase

         if (result.byte_accepted) begin
            // frame position of this byte is the count before the increment
            sum_in = sum_ff + req_payload.rx_byte;
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
               if (count_ff == 8'(FIRST_DATA_POS + k)) begin
                  store_in[k] = req_payload.rx_byte;
               end
            end
         end else begin
            clear = 1'b1;
         end

         if (result.frame_done) begin
            result.frame_length = len_in;
            result.command_code = cmd_in;
            for (int k = 0; k < WORD_BYTES; k++) begin
               if (k < PAYLOAD_BYTES) begin
                  result.payload_word[8*(WORD_BYTES-1-k) +: 8] = store_in[k];
               end
            end
            clear = 1'b1;
         end
      end

      if (clear) begin
         phase_in = PH_IDLE;
         count_in = 8'd0;
         len_in   = 8'd0;
         sum_in   = 8'd0;
         armed_in = 1'b0;
         tick_in  = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= 8'd0;
         len_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         cmd_ff   <= 8'd0;
         armed_ff <= 1'b0;
         tick_ff  <= 16'd0;
         for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            store_ff[k] <= 8'd0;
         end
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         cmd_ff   <= cmd_in;
         armed_ff <= armed_in;
         tick_ff  <= tick_in;
         for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            store_ff[k] <= store_in[k];
         end
      end
   end

   // ---------------- output register and skid stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (accept && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end else if (out_free) begin
         // advance the held beat, or drain
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && out_free) begin
         out_ff <= result;
      end else if (accept) begin
         skid_ff <= result;
      end else if (out_free && skid_valid_ff) begin
         out_ff <= skid_ff;
      end
   end

   // ---------------- assertions ----------------
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a beat while the output stage is empty");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({out_ff.frame_error, out_ff.timed_out, out_ff.frame_done}))
      else $error("more than one outcome flag in a result");

   a_done_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_ff.frame_done) |-> out_ff.byte_accepted)
      else $error("completed frame without its final byte accepted");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (count_ff == 8'd0 && sum_ff == 8'd0))
      else $error("idle parser holds a byte count or checksum");

   a_tick_disarmed: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.operation == OP_TICK && result.timed_out) |=> !armed_ff)
      else $error("timeout left the tick counter armed");

endmodule

`default_nettype wire
